// File: rtl/core/swmm_pkg.sv
package swmm_pkg;

  // Default depth of the sample chain
  localparam int unsigned MAX_WINDOW_DEF = 64;

  // Field widths
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned AGE_W     = 6;
  localparam int unsigned WIN_REG_W = 7;

  // Configuration register file
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [WIN_REG_W-1:0] WIN_RESET = 7'd64;

  // Register indexes (byte address / 4)
  typedef enum logic {
    REG_WINDOW_LENGTH = 1'b0,
    REG_UNUSED        = 1'b1
  } reg_idx_e;

  // State of one cell as handed to its older neighbor
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       lo_alive;
    logic                       hi_alive;
  } cell_link_t;

  // Front of one queue: extreme value and its age
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [AGE_W-1:0]           age;
  } front_t;

endpackage

// File: rtl/core/swmm_intf.sv
// Sample request channel
interface swmm_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swmm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Result request channel
interface swmm_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swmm_pkg::SAMPLE_W-1:0] min_value;
  logic signed [swmm_pkg::SAMPLE_W-1:0] max_value;
  logic [swmm_pkg::AGE_W-1:0]           min_age;
  logic [swmm_pkg::AGE_W-1:0]           max_age;
  logic                                 window_full;

  modport source (output valid, output min_value, output max_value, output min_age,
                  output max_age, output window_full, input ready);
  modport sink   (input valid, input min_value, input max_value, input min_age,
                  input max_age, input window_full, output ready);
endinterface

// File: rtl/core/swmm_cell.sv
module swmm_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned WW    = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [WW-1:0]                        eff_w_i,
  input  swmm_pkg::cell_link_t                 link_i,
  output swmm_pkg::cell_link_t                 link_o
);

  logic signed [swmm_pkg::SAMPLE_W-1:0] value_q;
  logic                                 lo_alive_q, lo_alive_d;
  logic                                 hi_alive_q, hi_alive_d;
  logic                                 in_window;
  logic                                 lo_keep, hi_keep;

  // Sample lands at age INDEX; it survives only inside the window
  assign in_window = (WW'(INDEX) < eff_w_i);

  // Newest cell takes the new sample as is; older cells must still beat it
  assign lo_keep = (INDEX == 0) || (link_i.value < sample_i);
  assign hi_keep = (INDEX == 0) || (link_i.value > sample_i);

  always_comb begin
    lo_alive_d = lo_alive_q;
    hi_alive_d = hi_alive_q;
    if (shift_i) begin
      lo_alive_d = link_i.lo_alive && lo_keep && in_window;
      hi_alive_d = link_i.hi_alive && hi_keep && in_window;
    end
  end

  // Membership flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_alive_q <= 1'b0;
      hi_alive_q <= 1'b0;
    end else begin
      lo_alive_q <= lo_alive_d;
      hi_alive_q <= hi_alive_d;
    end
  end

  // Sample value moves one cell older per request
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      value_q <= link_i.value;
    end
  end

  assign link_o.value    = value_q;
  assign link_o.lo_alive = lo_alive_q;
  assign link_o.hi_alive = hi_alive_q;

endmodule

// File: rtl/core/swmm_front.sv
module swmm_front #(
  parameter int unsigned N      = 64,
  parameter bit          FIND_LO = 1'b1
) (
  input  swmm_pkg::cell_link_t links_i [N],
  output swmm_pkg::front_t     front_o
);

  localparam int unsigned IDX_W = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0]     alive;
  logic [IDX_W-1:0] idx;

  // Pick the queue's flag out of each cell
  always_comb begin
    for (int i = 0; i < N; i++) begin
      alive[i] = FIND_LO ? links_i[i].lo_alive : links_i[i].hi_alive;
    end
  end

  // Oldest live cell is the queue front
  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (alive[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  // Age equals the cell position, kept to the age field width
  assign front_o.value = links_i[idx].value;
  assign front_o.age   = swmm_pkg::AGE_W'(idx);

endmodule

// File: rtl/core/sliding_window_min_max.sv
// Channel   Dir  Handshake      Payload
// sample_i  in   valid/ready    sample (s32)
// result_o  out  valid/ready    min_value, max_value (s32), min_age, max_age (u6), window_full
// apb       in   psel/penable   window_length at byte 0 (u7, reset 64)
//
// One sample per clock sustained while the result side is not stalled.
// The cell chain shifts on every accepted sample; the front is found from the
// registered chain and held in the output register, whose load makes the result valid.
// A stalled result holds; one more sample may be taken while it waits.
// Reset clears all queue membership flags and the sample count, and sets window_length to 64.
module sliding_window_min_max #(
  parameter int unsigned MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  swmm_sample_if.sink                         sample_i,
  swmm_result_if.source                       result_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swmm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [swmm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [swmm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned SW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WW = (SW > swmm_pkg::WIN_REG_W) ? SW : swmm_pkg::WIN_REG_W;

  logic [swmm_pkg::WIN_REG_W-1:0] window_q;
  logic [WW-1:0]                  eff_w;
  logic [SW-1:0]                  seen_q, seen_d;
  logic                           accept;
  logic                           pending_q, pending_d;
  logic                           load_out;
  logic                           out_valid_q, out_valid_d;
  logic                           cfg_wr;
  swmm_pkg::reg_idx_e             reg_idx;
  swmm_pkg::cell_link_t           head;
  swmm_pkg::cell_link_t           links [MAX_WINDOW];
  swmm_pkg::front_t               lo_front, hi_front;
  swmm_pkg::front_t               lo_q, hi_q;
  logic                           full_q;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = swmm_pkg::reg_idx_e'(paddr[swmm_pkg::APB_ADDR_W-1]);
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == swmm_pkg::REG_WINDOW_LENGTH);

  always_comb begin
    case (reg_idx)
      swmm_pkg::REG_WINDOW_LENGTH: prdata = swmm_pkg::APB_DATA_W'(window_q);
      default:                     prdata = '0;
    endcase
  end

  // Effective window: zero acts as one, clamp at the chain depth
  always_comb begin
    if (window_q == '0) begin
      eff_w = WW'(1);
    end else if (WW'(window_q) > WW'(MAX_WINDOW)) begin
      eff_w = WW'(MAX_WINDOW);
    end else begin
      eff_w = WW'(window_q);
    end
  end

  // Handshake: output register parts the sides
  assign accept         = sample_i.valid && sample_i.ready;
  assign load_out       = pending_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !pending_q || load_out;

  always_comb begin
    pending_d = pending_q;
    if (accept) begin
      pending_d = 1'b1;
    end else if (load_out) begin
      pending_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    seen_d = seen_q;
    if (accept && (seen_q < SW'(MAX_WINDOW))) begin
      seen_d = seen_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= swmm_pkg::WIN_RESET;
      seen_q      <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        window_q <= pwdata[swmm_pkg::WIN_REG_W-1:0];
      end
      seen_q      <= seen_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  // New sample enters the newest cell as a member of both queues
  assign head.value    = sample_i.sample;
  assign head.lo_alive = 1'b1;
  assign head.hi_alive = 1'b1;

  // Sample chain, newest at cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swmm_cell #(
      .INDEX (i),
      .WW    (WW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .sample_i (sample_i.sample),
      .eff_w_i  (eff_w),
      .link_i   ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
      .link_o   (links[i])
    );
  end

  // Queue fronts
  swmm_front #(
    .N       (MAX_WINDOW),
    .FIND_LO (1'b1)
  ) u_lo_front (
    .links_i (links),
    .front_o (lo_front)
  );

  swmm_front #(
    .N       (MAX_WINDOW),
    .FIND_LO (1'b0)
  ) u_hi_front (
    .links_i (links),
    .front_o (hi_front)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      lo_q   <= lo_front;
      hi_q   <= hi_front;
      full_q <= (WW'(seen_q) >= eff_w);
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.min_value   = lo_q.value;
  assign result_o.max_value   = hi_q.value;
  assign result_o.min_age     = lo_q.age;
  assign result_o.max_age     = hi_q.age;
  assign result_o.window_full = full_q;

endmodule

// File: verif/sliding_window_min_max_checker.sv
`timescale 1ns / 100ps

// Watches the sample, result and APB channels, keeps its own copy of the window
// state and compares every accepted result with the oldest prediction.
module sliding_window_min_max_checker #(
  parameter int unsigned MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  swmm_sample_if                              sample_mon_i,
  swmm_result_if                              result_mon_i,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic                                pready_i,
  input  logic [swmm_pkg::APB_ADDR_W-1:0]     paddr_i,
  input  logic [swmm_pkg::APB_DATA_W-1:0]     pwdata_i,
  output int                                  err_count_o,
  output int                                  pending_o
);

  localparam int SIDE_MIN = 0;
  localparam int SIDE_MAX = 1;

  // One held sample: value and the position it arrived at
  typedef struct packed {
    logic signed [swmm_pkg::SAMPLE_W-1:0] value;
    logic [15:0]                          pos;
  } slot_t;

  typedef struct packed {
    logic signed [swmm_pkg::SAMPLE_W-1:0] min_value;
    logic signed [swmm_pkg::SAMPLE_W-1:0] max_value;
    logic [swmm_pkg::AGE_W-1:0]           min_age;
    logic [swmm_pkg::AGE_W-1:0]           max_age;
    logic                                 window_full;
  } window_result_t;

  // Monotonic queues, min side and max side
  slot_t           mono_q [2][MAX_WINDOW];
  int unsigned     mono_n [2];
  logic [15:0]     cur_pos;
  int unsigned     seen;
  logic [swmm_pkg::WIN_REG_W-1:0] win_len;

  window_result_t  expected_q [$];
  window_result_t  exp_r;

  // Advance both queues by one sample and return the window extremes
  function automatic window_result_t advance_window(
    input logic signed [swmm_pkg::SAMPLE_W-1:0] v
  );
    window_result_t r;
    int unsigned    eff;
    int unsigned    n;
    int unsigned    drop;
    slot_t          front [2];
    eff = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : win_len);
    for (int k = 0; k < 2; k++) begin
      n = mono_n[k];
      drop = 0;
      // age out the front
      while (drop < n && 16'(cur_pos - mono_q[k][drop].pos) >= eff) drop++;
      for (int i = 0; i + drop < n; i++) mono_q[k][i] = mono_q[k][i + drop];
      n -= drop;
      // pop back entries not strictly better; ties go to the newest
      while (n > 0 && !((k == SIDE_MIN) ?
                        ($signed(mono_q[k][n-1].value) < v) :
                        ($signed(mono_q[k][n-1].value) > v))) n--;
      mono_q[k][n] = '{value: v, pos: cur_pos};
      mono_n[k] = n + 1;
      front[k] = mono_q[k][0];
    end
    if (seen < MAX_WINDOW) seen++;
    r.min_value   = front[SIDE_MIN].value;
    r.max_value   = front[SIDE_MAX].value;
    r.min_age     = swmm_pkg::AGE_W'(cur_pos - front[SIDE_MIN].pos);
    r.max_age     = swmm_pkg::AGE_W'(cur_pos - front[SIDE_MAX].pos);
    r.window_full = (seen >= eff);
    cur_pos = cur_pos + 16'd1;
    return r;
  endfunction

  function automatic void cmp_field(input string name, input logic signed [63:0] exp_v,
                                    input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count_o++;
    end
  endfunction

  initial err_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_n[SIDE_MIN] = 0;
      mono_n[SIDE_MAX] = 0;
      cur_pos = '0;
      seen = 0;
      win_len = swmm_pkg::WIN_RESET;
      expected_q.delete();
      pending_o = 0;
    end else begin
      // register write, only ever done while idle
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[swmm_pkg::APB_ADDR_W-1:2] == swmm_pkg::REG_WINDOW_LENGTH) begin
        win_len = pwdata_i[swmm_pkg::WIN_REG_W-1:0];
      end
      // result side: compare with oldest prediction
      if (result_mon_i.valid && result_mon_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          err_count_o++;
        end else begin
          exp_r = expected_q[0];
          expected_q.delete(0);
          cmp_field("min_value", exp_r.min_value, result_mon_i.min_value);
          cmp_field("max_value", exp_r.max_value, result_mon_i.max_value);
          cmp_field("min_age", exp_r.min_age, result_mon_i.min_age);
          cmp_field("max_age", exp_r.max_age, result_mon_i.max_age);
          cmp_field("window_full", exp_r.window_full, result_mon_i.window_full);
        end
      end
      // request side: predict
      if (sample_mon_i.valid && sample_mon_i.ready) begin
        expected_q.push_back(advance_window(sample_mon_i.sample));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: verif/sliding_window_min_max_tb.sv
`timescale 1ns / 100ps

module sliding_window_min_max_tb;

  localparam int IDLE_PCT = 61;
  localparam int BOTH_PCT = 31;
  localparam int N_PHASES = 14;
  localparam int PHASE_ITEMS = 118;

  // stream shapes for the random part
  localparam int PAT_NOISE   = 0;
  localparam int PAT_TIES    = 1;
  localparam int PAT_RISE    = 2;
  localparam int PAT_FALL    = 3;
  localparam int PAT_EXTREME = 4;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [swmm_pkg::APB_ADDR_W-1:0] paddr;
  logic [swmm_pkg::APB_DATA_W-1:0] pwdata;
  logic [swmm_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  int err_count;
  int pending;
  int src_idle_pct;
  int sink_stall_pct;

  int unsigned phase_win [N_PHASES] = '{1, 64, 2, 127, 0, 3, 17, 63, 65, 5, 32, 8, 64, 100};

  swmm_sample_if smp_if ();
  swmm_result_if res_if ();

  sliding_window_min_max u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sample_i(smp_if),
    .result_o(res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sliding_window_min_max_checker u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .sample_mon_i(smp_if),
    .result_mon_i(res_if),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result receiver, random backpressure
  always @(negedge clk) begin
    res_if.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // drop valid and hold until every outstanding result is back
  task automatic wait_drained();
    smp_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(input swmm_pkg::reg_idx_e idx,
                           input logic [swmm_pkg::APB_DATA_W-1:0] data);
    wait_drained();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = swmm_pkg::APB_ADDR_W'(idx) << 2;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // window length with random don't-care upper bits
  task automatic set_window(input int unsigned len);
    apb_write(swmm_pkg::REG_WINDOW_LENGTH,
              {(swmm_pkg::APB_DATA_W - swmm_pkg::WIN_REG_W)'($urandom()),
               swmm_pkg::WIN_REG_W'(len)});
  endtask

  task automatic send_sample(input logic signed [swmm_pkg::SAMPLE_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      smp_if.valid = 1'b0;
      @(negedge clk);
    end
    smp_if.valid  = 1'b1;
    smp_if.sample = v;
    do @(posedge clk); while (!smp_if.ready);
    @(negedge clk);
  endtask

  // random stream built from runs of one shape each
  task automatic send_stream(input int count);
    int left;
    int kind;
    int len;
    logic signed [swmm_pkg::SAMPLE_W-1:0] base;
    logic signed [swmm_pkg::SAMPLE_W-1:0] step;
    logic signed [swmm_pkg::SAMPLE_W-1:0] v;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(PAT_EXTREME);
      len  = $urandom_range(80, 1);
      if (len > left) len = left;
      base = $urandom();
      step = $urandom_range(1 << 20, 1);
      for (int i = 0; i < len; i++) begin
        case (kind)
          PAT_NOISE: v = $urandom();
          PAT_TIES:  v = $signed($urandom_range(8)) - 4;
          PAT_RISE:  v = base + swmm_pkg::SAMPLE_W'(i) * step;
          PAT_FALL:  v = base - swmm_pkg::SAMPLE_W'(i) * step;
          PAT_EXTREME: begin
            case ($urandom_range(3))
              0:       v = 32'sh8000_0000;
              1:       v = 32'sh7fff_ffff;
              2:       v = '0;
              default: v = -1;
            endcase
          end
          default:   v = '0;
        endcase
        send_sample(v);
      end
      left -= len;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    smp_if.valid   = 1'b0;
    smp_if.sample  = '0;
    res_if.ready   = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset window, field extremes, ties, falling run
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(0);
    send_sample(-1);
    send_sample(1);
    send_sample(5);
    send_sample(5);
    send_sample(5);
    send_sample(3);
    send_sample(2);
    send_sample(32'sh7fff_ffff);
    // zero window acts as one
    set_window(0);
    send_sample(3);
    send_sample(1);
    send_sample(2);
    // oversized window clamps to the maximum
    set_window(127);
    send_sample(-5);
    send_sample(-5);
    // short window, then grown mid-stream
    set_window(4);
    send_sample(9);
    send_sample(8);
    send_sample(7);
    send_sample(6);
    send_sample(10);
    send_sample(11);
    set_window(64);
    send_sample(1);
    send_sample(12);
    send_sample(0);
    // unused register must not disturb the window
    apb_write(swmm_pkg::REG_UNUSED, $urandom());
    send_sample(4);

    // random phases, cycling through the idle/stall mixes
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      set_window(phase_win[p]);
      case (p % 4)
        1:       src_idle_pct = IDLE_PCT;
        2:       sink_stall_pct = IDLE_PCT;
        3: begin
          src_idle_pct   = BOTH_PCT;
          sink_stall_pct = BOTH_PCT;
        end
        default: ;
      endcase
      send_stream(PHASE_ITEMS / 2);
      // hold off until the pipe is empty
      wait_drained();
      send_stream(PHASE_ITEMS - PHASE_ITEMS / 2);
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
